// ===== hdl/lrpwm_pkg.sv =====
// shared constants, types and chain mapping for the led ring brightness table
package lrpwm_pkg;

    localparam int LED_COUNT = 24;
    localparam int POS_W     = 5;
    localparam int LEVEL_W   = 7;
    localparam int VALUE_W   = 8;
    localparam int FRAME_W   = 7;
    localparam int MODE_W    = 2;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 7'd100;

    localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [POS_W-1:0]          led_position;
        logic signed [VALUE_W-1:0] brightness_value;
        logic [POS_W-1:0]          chain_position;
        logic [FRAME_W-1:0]        frame_count;
    } lrpwm_op_t;

    // serial chain position to visual position, only meaningful below LED_COUNT
    function automatic logic [POS_W-1:0] chain_to_visual(input logic [POS_W-1:0] chain);
        logic [POS_W-1:0] vis;
        vis = '0;
        case (chain) inside
            [5'd0:5'd7]:   vis = 5'd11 - chain;
            [5'd8:5'd15]:  vis = 5'd27 - chain;
            [5'd16:5'd19]: vis = 5'd19 - chain;
            [5'd20:5'd23]: vis = 5'd23 - (chain - 5'd20);
            default:       vis = '0;
        endcase
        return vis;
    endfunction

endpackage

// ===== hdl/lrpwm_table.sv =====
// brightness register file with set, add, clear and query logic
module lrpwm_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_en,
    input  lrpwm_pkg::lrpwm_op_t op,
    output logic               query_on
);
    import lrpwm_pkg::*;

    logic [LEVEL_W-1:0] level_reg [LED_COUNT];
    logic [LEVEL_W-1:0] level_next [LED_COUNT];

    logic [POS_W-1:0]          rd_addr;
    logic                      rd_in_range;
    logic [LEVEL_W-1:0]        rd_level;
    logic signed [VALUE_W:0]   add_sum;
    logic [LEVEL_W-1:0]        set_level;
    logic [LEVEL_W-1:0]        add_level;
    logic [LEVEL_W-1:0]        wr_level;
    logic                      wr_en;
    logic                      clr_en;

    // one read port: query reads the mapped slot, add reads its own slot
    assign rd_addr = (op.mode == MODE_QUERY) ? chain_to_visual(op.chain_position)
                                             : op.led_position;
    assign rd_in_range = (op.mode == MODE_QUERY)
                       ? (op.chain_position < POS_W'(LED_COUNT))
                       : (op.led_position < POS_W'(LED_COUNT));
    assign rd_level = rd_in_range ? level_reg[rd_addr] : '0;

    always_comb
    begin
        if (op.brightness_value < 0)
            set_level = '0;
        else if (op.brightness_value > $signed({1'b0, MAX_LEVEL}))
            set_level = MAX_LEVEL;
        else
            set_level = op.brightness_value[LEVEL_W-1:0];
    end

    assign add_sum = $signed({2'b00, rd_level})
                   + $signed({op.brightness_value[VALUE_W-1], op.brightness_value});

    always_comb
    begin
        if (add_sum < 0)
            add_level = '0;
        else if (add_sum > $signed({2'b00, MAX_LEVEL}))
            add_level = MAX_LEVEL;
        else
            add_level = add_sum[LEVEL_W-1:0];
    end

    always_comb
    begin
        wr_level = set_level;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        unique case (op.mode)
            MODE_SET:
            begin
                wr_level = set_level;
                wr_en    = op_en && (op.led_position < POS_W'(LED_COUNT));
            end
            MODE_ADD:
            begin
                wr_level = add_level;
                wr_en    = op_en && (op.led_position < POS_W'(LED_COUNT));
            end
            MODE_CLEAR:
                clr_en = op_en;
            default:
                wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if (clr_en)
                level_next[i] = '0;
            else if (wr_en && (op.led_position == POS_W'(i)))
                level_next[i] = wr_level;
            else
                level_next[i] = level_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
                level_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < LED_COUNT; i++)
                level_reg[i] <= level_next[i];
        end
    end

    // out-of-range chain position reads as zero brightness, so never on
    assign query_on = (rd_level > op.frame_count);

endmodule

// ===== hdl/led_ring_pwm_brightness_table.sv =====
// top level of the led ring pwm brightness table
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid / in_stall    | mode, led_position, brightness_value,
//          |                        | chain_position, frame_count
//  out     | out_valid / out_stall  | led_on (one item per query, none otherwise)
//
// one item per cycle while in_stall is low; an item is held in the input register and
// applied to the 24-entry brightness register file from there.
// a query result goes on from the input register to the output register.
// reset clears every brightness to zero at once.
// a stalled result holds; in_stall rises only when a query waits on a full,
// stalled output register.
module led_ring_pwm_brightness_table (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [lrpwm_pkg::MODE_W-1:0]           mode,
    input  logic [lrpwm_pkg::POS_W-1:0]            led_position,
    input  logic signed [lrpwm_pkg::VALUE_W-1:0]   brightness_value,
    input  logic [lrpwm_pkg::POS_W-1:0]            chain_position,
    input  logic [lrpwm_pkg::FRAME_W-1:0]          frame_count,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   led_on
);
    import lrpwm_pkg::*;

    logic      op_valid_reg;
    lrpwm_op_t op_reg;
    logic      out_valid_reg;
    logic      led_on_reg;
    logic      query_on;
    logic      is_query;
    logic      op_go;
    logic      in_take;

    assign is_query = (op_reg.mode == MODE_QUERY);
    // only a query needs room in the output register
    assign op_go    = op_valid_reg && (!is_query || !out_valid_reg || !out_stall);
    assign in_stall = op_valid_reg && !op_go;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_valid_reg <= 1'b0;
        else if (in_take)
            op_valid_reg <= 1'b1;
        else if (op_go)
            op_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg.mode             <= mode;
            op_reg.led_position     <= led_position;
            op_reg.brightness_value <= brightness_value;
            op_reg.chain_position   <= chain_position;
            op_reg.frame_count      <= frame_count;
        end
    end

    lrpwm_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_en    (op_go),
        .op       (op_reg),
        .query_on (query_on)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (op_go && is_query)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op_go && is_query)
            led_on_reg <= query_on;
    end

    assign out_valid = out_valid_reg;
    assign led_on    = led_on_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (op_valid_reg && is_query && out_valid_reg))
        else $error("input stalled without a blocked query");

    a_query_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (op_go && is_query) |=> out_valid)
        else $error("query result missing from output register");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(op_go && is_query))
        else $error("query overwrote a stalled result");

endmodule

// ===== tb/sv/led_ring_pwm_brightness_table_tb.sv =====
// testbench for the led ring pwm brightness table: directed and random items, scoreboard check
class brightness_mirror;

    logic [lrpwm_pkg::LEVEL_W-1:0] level [lrpwm_pkg::LED_COUNT];
    bit                            expected_on [$];
    int                            errors;

    // serial chain position to visual position, as wired on the ring
    byte unsigned chain_map [lrpwm_pkg::LED_COUNT] = '{
        11, 10, 9, 8, 7, 6, 5, 4,
        19, 18, 17, 16, 15, 14, 13, 12,
        3, 2, 1, 0,
        23, 22, 21, 20
    };

    function new();
        foreach (level[i])
        begin
            level[i] = '0;
        end
        errors = 0;
    endfunction

    function logic [lrpwm_pkg::LEVEL_W-1:0] clamp(int x);
        if (x < 0)
        begin
            return '0;
        end
        if (x > 100)
        begin
            return lrpwm_pkg::MAX_LEVEL;
        end
        return x[lrpwm_pkg::LEVEL_W-1:0];
    endfunction

    // update the mirrored table for one accepted item, queue a result for a query
    function void note_item(logic [lrpwm_pkg::MODE_W-1:0] m,
                            logic [lrpwm_pkg::POS_W-1:0] p,
                            logic signed [lrpwm_pkg::VALUE_W-1:0] v,
                            logic [lrpwm_pkg::POS_W-1:0] c,
                            logic [lrpwm_pkg::FRAME_W-1:0] f);
        int lv;
        int dv;
        int vis;
        case (m)
            lrpwm_pkg::MODE_SET:
            begin
                if (p < lrpwm_pkg::LED_COUNT)
                begin
                    level[p] = clamp(v);
                end
            end
            lrpwm_pkg::MODE_ADD:
            begin
                if (p < lrpwm_pkg::LED_COUNT)
                begin
                    lv = level[p];
                    dv = v;
                    level[p] = clamp(lv + dv);
                end
            end
            lrpwm_pkg::MODE_CLEAR:
            begin
                foreach (level[i])
                begin
                    level[i] = '0;
                end
            end
            lrpwm_pkg::MODE_QUERY:
            begin
                if (c < lrpwm_pkg::LED_COUNT)
                begin
                    vis = chain_map[c];
                    expected_on.push_back(level[vis] > f);
                end
                else
                begin
                    expected_on.push_back(1'b0);
                end
            end
        endcase
    endfunction

    function void check_led_on(logic act);
        bit exp_on;
        if (expected_on.size() == 0)
        begin
            $display("%0t: unexpected item, expected none, actual led_on %0b", $time, act);
            errors++;
        end
        else
        begin
            exp_on = expected_on.pop_front();
            if (act !== exp_on)
            begin
                $display("%0t: led_on mismatch, expected %0b, actual %0b", $time, exp_on, act);
                errors++;
            end
        end
    endfunction

    function void flush_leftovers();
        while (expected_on.size() != 0)
        begin
            $display("%0t: missing item, expected led_on %0b, actual none",
                     $time, expected_on.pop_front());
            errors++;
        end
    endfunction

endclass

module led_ring_pwm_brightness_table_tb;

    import lrpwm_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          led_position;
    logic signed [VALUE_W-1:0] brightness_value;
    logic [POS_W-1:0]          chain_position;
    logic [FRAME_W-1:0]        frame_count;
    logic                      out_valid;
    logic                      out_stall;
    logic                      led_on;

    bit in_gaps;
    bit out_gaps;

    brightness_mirror mirror = new();

    led_ring_pwm_brightness_table dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .led_position     (led_position),
        .brightness_value (brightness_value),
        .chain_position   (chain_position),
        .frame_count      (frame_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .led_on           (led_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // results are checked before the item of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                mirror.check_led_on(led_on);
            end
            if (in_valid && !in_stall)
            begin
                mirror.note_item(mode, led_position, brightness_value, chain_position,
                                 frame_count);
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    function automatic int pick_pos();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
    endfunction

    // called at a rising edge; returns at the edge where the item is accepted
    task automatic send_item(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
                             logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] c,
                             logic [FRAME_W-1:0] f);
        if (in_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid         <= 1'b0;
            mode             <= MODE_W'($urandom_range(0, 3));
            led_position     <= POS_W'($urandom_range(0, 31));
            brightness_value <= VALUE_W'($urandom_range(0, 255));
            chain_position   <= POS_W'($urandom_range(0, 31));
            frame_count      <= FRAME_W'($urandom_range(0, 127));
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= m;
        led_position     <= p;
        brightness_value <= v;
        chain_position   <= c;
        frame_count      <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_set(logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v);
        send_item(MODE_SET, p, v, POS_W'($urandom_range(0, 31)),
                  FRAME_W'($urandom_range(0, 127)));
    endtask

    task automatic send_add(logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v);
        send_item(MODE_ADD, p, v, POS_W'($urandom_range(0, 31)),
                  FRAME_W'($urandom_range(0, 127)));
    endtask

    task automatic send_query(logic [POS_W-1:0] c, logic [FRAME_W-1:0] f);
        send_item(MODE_QUERY, POS_W'($urandom_range(0, 31)),
                  VALUE_W'($urandom_range(0, 255)), c, f);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, POS_W'($urandom_range(0, 31)),
                  VALUE_W'($urandom_range(0, 255)),
                  POS_W'($urandom_range(0, 31)), FRAME_W'($urandom_range(0, 127)));
    endtask

    initial
    begin
        int kind;
        int v;
        int waited;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        mode             = '0;
        led_position     = '0;
        brightness_value = '0;
        chain_position   = '0;
        frame_count      = '0;
        in_gaps          = 1'b0;
        out_gaps         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, clamping, saturation, ranges, chain wiring
        send_query(5'd0, 7'd0);
        send_set(5'd0, 8'sd100);
        send_query(5'd19, 7'd99);
        send_query(5'd19, 7'd100);
        send_set(5'd23, 8'sd127);
        send_query(5'd20, 7'd99);
        send_set(5'd4, -8'sd128);
        send_query(5'd7, 7'd0);
        send_set(5'd12, 8'sd50);
        send_query(5'd15, 7'd49);
        send_add(5'd12, 8'sd100);
        send_query(5'd15, 7'd127);
        send_add(5'd12, -8'sd128);
        send_query(5'd15, 7'd0);
        send_set(5'd31, 8'sd77);
        send_add(5'd24, 8'sd40);
        send_query(5'd31, 7'd0);
        send_query(5'd24, 7'd0);
        send_set(5'd19, 8'sd60);
        send_query(5'd8, 7'd59);
        send_add(5'd11, 8'sd5);
        send_query(5'd0, 7'd4);
        send_clear();
        send_query(5'd8, 7'd0);
        send_query(5'd20, 7'd0);

        for (int n = 0; n < 1650; n++)
        begin
            if (n % 150 == 0)
            begin
                // idling mode per stretch; none near the end
                if (n >= 1450)
                begin
                    {in_gaps, out_gaps} = 2'b00;
                end
                else
                begin
                    {in_gaps, out_gaps} = 2'($urandom_range(0, 3));
                end
            end
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                case ($urandom_range(0, 9))
                    0:       v = $urandom_range(0, 255);
                    1:       v = $urandom_range(0, 40) - 20;
                    2:       v = $urandom_range(90, 127);
                    default: v = $urandom_range(0, 100);
                endcase
                send_set(POS_W'(pick_pos()), VALUE_W'(v));
            end
            else if (kind < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    v = $urandom_range(0, 255);
                end
                else
                begin
                    v = $urandom_range(0, 60) - 30;
                end
                send_add(POS_W'(pick_pos()), VALUE_W'(v));
            end
            else if (kind < 63)
            begin
                send_clear();
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    v = $urandom_range(101, 127);
                end
                else
                begin
                    v = $urandom_range(0, 100);
                end
                send_query(POS_W'(pick_pos()), FRAME_W'(v));
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while (mirror.expected_on.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        mirror.flush_leftovers();
        if (mirror.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
